FILE: rtl/lqls_pkg.sv
// shared constants, types and address helper for the lane queue light scheduler
// no dependencies
`default_nettype none
package lqls_pkg;

    localparam int LANE_DEPTH = 64;
    localparam int LANE_COUNT = 4;
    localparam int ID_W       = 16;
    localparam int LANE_W     = 2;
    localparam int HEAD_W     = $clog2(LANE_DEPTH);
    localparam int CNT_W      = $clog2(LANE_DEPTH + 1);
    localparam int LVL_W      = 7;
    localparam int CMP_W      = (CNT_W > LVL_W) ? CNT_W : LVL_W;
    localparam int TOT_W      = CNT_W + 2;
    localparam int ADDR_W     = $clog2(LANE_COUNT * LANE_DEPTH);
    localparam int STORE_D    = LANE_COUNT * LANE_DEPTH;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_LANE   = 3'd4;

    localparam logic [TICK_W-1:0] GREEN_RESET = 8'd10;
    localparam logic [TICK_W-1:0] RED_RESET   = 8'd5;
    localparam logic [LVL_W-1:0]  ENTER_RESET = 7'd10;
    localparam logic [LVL_W-1:0]  EXIT_RESET  = 7'd5;

    typedef struct packed {
        logic              is_tick;
        logic [LANE_W-1:0] lane;
        logic [ID_W-1:0]   id;
    } t_cmd;

    typedef struct packed {
        logic [TICK_W-1:0] green_ticks;
        logic [TICK_W-1:0] red_ticks;
        logic [LVL_W-1:0]  enter_lvl;
        logic [LVL_W-1:0]  exit_lvl;
        logic [LANE_W-1:0] prio_lane;
    } t_cfg;

    typedef struct packed {
        logic              strobe;
        logic              served_valid;
        logic [LANE_W-1:0] served_lane;
        logic [ID_W-1:0]   served_id;
        logic              from_priority;
        logic              light_green;
        logic              priority_active;
        logic              overflow_seen;
        logic              last;
    } t_result;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [LANE_W-1:0] lane,
                                                 input logic [HEAD_W-1:0] slot);
        f_addr = ADDR_W'(lane) * ADDR_W'(LANE_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lqls_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none
module lqls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/lqls_front.sv
// front end: takes requests and classifies them into a two-entry command queue
// depends on lqls_pkg
`default_nettype none
module lqls_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_mode,
    input  wire logic [lqls_pkg::LANE_W-1:0] i_lane,
    input  wire logic [lqls_pkg::ID_W-1:0]  i_vehicle_id,
    output logic                            o_busy,
    output logic                            o_q_valid,
    output lqls_pkg::t_cmd                  o_q_cmd,
    input  wire logic                       i_q_pop
);
    import lqls_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_fill;
    logic       push;

    assign o_busy    = (r_fill == 2'd2);
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr].is_tick <= i_mode;
            r_q[r_wr].lane    <= i_lane;
            r_q[r_wr].id      <= i_vehicle_id;
        end
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            case ({push, i_q_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lqls_back.sv
// back end: lane queues, light countdown, priority hysteresis and serving
// depends on lqls_pkg and lqls_ram
`default_nettype none
module lqls_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  lqls_pkg::t_cfg    i_cfg,
    input  wire logic         i_q_valid,
    input  lqls_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output lqls_pkg::t_result o_res
);
    import lqls_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_NONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt  [LANE_COUNT];
    logic [CNT_W-1:0]  n_cnt  [LANE_COUNT];
    logic [HEAD_W-1:0] r_head [LANE_COUNT];
    logic [HEAD_W-1:0] n_head [LANE_COUNT];
    logic              r_green, n_green;
    logic [TICK_W-1:0] r_remain, n_remain;
    logic              r_prio, n_prio;
    logic              r_drop, n_drop;
    logic [CNT_W-1:0]  r_quota, n_quota;
    logic [LANE_W-1:0] r_idx, n_idx;
    logic [2:0]        r_n, n_n;
    logic [LANE_W-1:0] r_lane, n_lane;
    logic              r_fprio, n_fprio;
    logic              r_last, n_last;
    t_result           r_res, n_res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ID_W-1:0]   ram_rdata;

    logic [CNT_W-1:0]  cpl, cidx, carr;
    logic [CNT_W:0]    tail_sum;
    logic [HEAD_W-1:0] tail;
    logic [TOT_W-1:0]  total;
    logic              enter, more;
    logic [LANE_COUNT-1:0] nonempty;

    lqls_ram #(.WIDTH(ID_W), .DEPTH(STORE_D)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_cmd.id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_res = r_res;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_green  = r_green;
        n_remain = r_remain;
        n_prio   = r_prio;
        n_drop   = r_drop;
        n_quota  = r_quota;
        n_idx    = r_idx;
        n_n      = r_n;
        n_lane   = r_lane;
        n_fprio  = r_fprio;
        n_last   = r_last;
        n_res    = r_res;
        n_res.strobe = 1'b0;
        o_q_pop  = 1'b0;
        ram_we   = 1'b0;

        carr     = r_cnt[i_q_cmd.lane];
        tail_sum = (CNT_W+1)'(r_head[i_q_cmd.lane]) + (CNT_W+1)'(carr);
        if (tail_sum >= (CNT_W+1)'(LANE_DEPTH)) begin
            tail = HEAD_W'(tail_sum - (CNT_W+1)'(LANE_DEPTH));
        end else begin
            tail = HEAD_W'(tail_sum);
        end
        ram_waddr = f_addr(i_q_cmd.lane, tail);
        ram_raddr = f_addr(r_idx, r_head[r_idx]);

        cpl   = r_cnt[i_cfg.prio_lane];
        cidx  = r_cnt[r_idx];
        enter = !r_prio && (CMP_W'(cpl) > CMP_W'(i_cfg.enter_lvl));
        total = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            total       = total + TOT_W'(r_cnt[i]);
            nonempty[i] = (r_cnt[i] != '0);
        end
        more = 1'b0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (i > int'(r_idx) && nonempty[i]) begin
                more = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!i_q_cmd.is_tick) begin
                        if (carr >= CNT_W'(LANE_DEPTH)) begin
                            n_drop = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            n_cnt[i_q_cmd.lane] = carr + 1'b1;
                        end
                    end else begin
                        if (r_remain <= TICK_W'(1)) begin
                            n_green  = !r_green;
                            n_remain = r_green ? i_cfg.red_ticks : i_cfg.green_ticks;
                        end else begin
                            n_remain = r_remain - 1'b1;
                        end
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!r_green) begin
                    n_state = S_NONE;
                end else if (r_prio || enter) begin
                    if (cpl != '0) begin
                        ram_raddr = f_addr(i_cfg.prio_lane, r_head[i_cfg.prio_lane]);
                        n_cnt[i_cfg.prio_lane] = cpl - 1'b1;
                        if (r_head[i_cfg.prio_lane] == HEAD_W'(LANE_DEPTH - 1)) begin
                            n_head[i_cfg.prio_lane] = '0;
                        end else begin
                            n_head[i_cfg.prio_lane] = r_head[i_cfg.prio_lane] + 1'b1;
                        end
                        n_prio  = !(CMP_W'(cpl - 1'b1) < CMP_W'(i_cfg.exit_lvl));
                        n_lane  = i_cfg.prio_lane;
                        n_fprio = 1'b1;
                        n_last  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_prio  = !(CMP_W'(cpl) < CMP_W'(i_cfg.exit_lvl));
                        n_state = S_NONE;
                    end
                end else if (total == '0) begin
                    n_state = S_NONE;
                end else begin
                    n_quota = CNT_W'(total >> 2);
                    if (n_quota == '0) begin
                        n_quota = CNT_W'(1);
                    end
                    n_idx   = '0;
                    n_n     = '0;
                    n_fprio = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cidx != '0) begin
                    n_cnt[r_idx] = cidx - 1'b1;
                    if (r_head[r_idx] == HEAD_W'(LANE_DEPTH - 1)) begin
                        n_head[r_idx] = '0;
                    end else begin
                        n_head[r_idx] = r_head[r_idx] + 1'b1;
                    end
                    n_lane  = r_idx;
                    n_n     = r_n + 3'd1;
                    n_last  = (CNT_W'(n_n) == r_quota) || !more;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                n_res.strobe          = 1'b1;
                n_res.served_valid    = 1'b1;
                n_res.served_lane     = r_lane;
                n_res.served_id       = ram_rdata;
                n_res.from_priority   = r_fprio;
                n_res.light_green     = r_green;
                n_res.priority_active = r_prio;
                n_res.overflow_seen   = r_drop;
                n_res.last            = r_last;
                if (r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_NONE: begin
                n_res.strobe          = 1'b1;
                n_res.served_valid    = 1'b0;
                n_res.served_lane     = '0;
                n_res.served_id       = '0;
                n_res.from_priority   = 1'b0;
                n_res.light_green     = r_green;
                n_res.priority_active = r_prio;
                n_res.overflow_seen   = r_drop;
                n_res.last            = 1'b1;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_quota <= n_quota;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_lane  <= n_lane;
        r_fprio <= n_fprio;
        r_last  <= n_last;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_green  <= 1'b1;
            r_remain <= GREEN_RESET;
            r_prio   <= 1'b0;
            r_drop   <= 1'b0;
            r_res    <= '0;
            for (int i = 0; i < LANE_COUNT; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_green  <= n_green;
            r_remain <= n_remain;
            r_prio   <= n_prio;
            r_drop   <= n_drop;
            r_res    <= n_res;
            r_cnt    <= n_cnt;
            r_head   <= n_head;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lane_queue_light_scheduler.sv
// top level: configuration registers, front end and back end
// depends on lqls_pkg, lqls_front, lqls_back
//
//  channel   handshake            fields
//  request   start / busy         i_mode, i_lane, i_vehicle_id
//  result    o_strobe (1 cycle)   o_served_*, o_from_priority, o_light_green,
//                                 o_priority_active, o_overflow_seen, o_last
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
//  an arrival is handled in the idle state; a tick passes the decide state, then gives a
//  result with no vehicle, or a priority serve through emit, or in normal mode scan and
//  emit per vehicle served, with scan stepping over each empty lane that it meets
//  the lanes share one store whose single read port is registered, read ahead of emit
//  busy rises while two requests wait in the command queue
//  synchronous active low reset, no store clearing pass; results cannot be held off
`default_nettype none
module lane_queue_light_scheduler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_mode,
    input  wire logic [lqls_pkg::LANE_W-1:0]    i_lane,
    input  wire logic [lqls_pkg::ID_W-1:0]      i_vehicle_id,
    input  wire logic                           i_cfg_we,
    input  wire logic [lqls_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lqls_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_served_valid,
    output logic [lqls_pkg::LANE_W-1:0]         o_served_lane,
    output logic [lqls_pkg::ID_W-1:0]           o_served_id,
    output logic                                o_from_priority,
    output logic                                o_light_green,
    output logic                                o_priority_active,
    output logic                                o_overflow_seen,
    output logic                                o_last
);
    import lqls_pkg::*;

    t_cfg    r_cfg;
    t_cmd    q_cmd;
    t_result res;
    logic    q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.green_ticks <= GREEN_RESET;
            r_cfg.red_ticks   <= RED_RESET;
            r_cfg.enter_lvl   <= ENTER_RESET;
            r_cfg.exit_lvl    <= EXIT_RESET;
            r_cfg.prio_lane   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GREEN_TICKS: r_cfg.green_ticks <= i_cfg_data[TICK_W-1:0];
                REG_RED_TICKS:   r_cfg.red_ticks   <= i_cfg_data[TICK_W-1:0];
                REG_ENTER_LEVEL: r_cfg.enter_lvl   <= i_cfg_data[LVL_W-1:0];
                REG_EXIT_LEVEL:  r_cfg.exit_lvl    <= i_cfg_data[LVL_W-1:0];
                REG_PRIO_LANE:   r_cfg.prio_lane   <= i_cfg_data[LANE_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    lqls_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_mode       (i_mode),
        .i_lane       (i_lane),
        .i_vehicle_id (i_vehicle_id),
        .o_busy       (busy),
        .o_q_valid    (q_valid),
        .o_q_cmd      (q_cmd),
        .i_q_pop      (q_pop)
    );

    lqls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (res)
    );

    assign o_strobe          = res.strobe;
    assign o_served_valid    = res.served_valid;
    assign o_served_lane     = res.served_lane;
    assign o_served_id       = res.served_id;
    assign o_from_priority   = res.from_priority;
    assign o_light_green     = res.light_green;
    assign o_priority_active = res.priority_active;
    assign o_overflow_seen   = res.overflow_seen;
    assign o_last            = res.last;
endmodule
`default_nettype wire
